// ----- sv/swva_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding-window vector average package
// Widths, codes, state encoding and the request and response structs shared
// by the averager top level, its divider and its checker.
// ----------------------------------------------------------------------------
package swva_pkg;

    localparam int WINDOW_MAX = 256;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 24;
    localparam int MEAN_W     = 16;
    localparam int LEN_W      = 9;
    localparam int AXES       = 3;
    localparam int AXIS_W     = $clog2(AXES);
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int POS_W      = CNT_W + 1;
    localparam int STEP_W     = $clog2(SUM_W);
    localparam int ENTRY_W    = AXES * SAMPLE_W;

    localparam int IN_TDATA_W   = ((ENTRY_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = CNT_W + AXES * SUM_W + AXES * MEAN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam int MEAN_LIM = 1 << (MEAN_W - 1);
    localparam logic signed [MEAN_W-1:0] MEAN_MAX = MEAN_W'(MEAN_LIM - 1);
    localparam logic signed [MEAN_W-1:0] MEAN_MIN = MEAN_W'(MEAN_LIM);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [MEAN_W-1:0]   t_mean;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_CLEAR  = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_PUSH,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic             start;
        t_sum             dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_mean quotient;
    } t_div_rsp;

endpackage

// ----- sv/sliding_window_vector_average.sv -----
// ----------------------------------------------------------------------------
// Sliding-window vector average
// Keeps the newest samples of a three-axis stream in a ring RAM, holds a
// running sum per axis and reports count, sums and means for every word.
//
// Channel   Dir  Handshake             Contents
// s         in   i_s_tvalid/o_s_tready tdata samples x,y,z; tuser opcode
// m         out  o_m_tvalid/i_m_tready tdata count, sums x,y,z, means x,y,z
// apb       in   psel/penable/pready   window_length at byte address 0
//
// An append passes the drop state when the oldest sample goes, then the push
// state, the shared divider on each of the three axes in turn and the load
// state. A clear goes straight to the load state. One word is in work at a
// time; the next word is taken as soon as the finished result sits in the
// output register. Reset is synchronous and needs no clearing pass; a stall on
// the output holds the result and the sequencer waits in its load state.
// ----------------------------------------------------------------------------
module sliding_window_vector_average (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // sample_x, sample_y, sample_z
    input  logic [swva_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // opcode
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // entry_count, sum_x, sum_y, sum_z, mean_x, mean_y, mean_z, zero fill
    output logic [swva_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swva_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [swva_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [swva_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    swva_pkg::t_state                   r_state, n_state;
    logic [swva_pkg::LEN_W-1:0]         r_len, n_len;
    logic [swva_pkg::PTR_W-1:0]         r_ptr, n_ptr;
    logic [swva_pkg::CNT_W-1:0]         r_count, n_count;
    logic [swva_pkg::AXIS_W-1:0]        r_axis, n_axis;
    swva_pkg::t_sum                     r_sum [swva_pkg::AXES];
    swva_pkg::t_sum                     n_sum [swva_pkg::AXES];
    swva_pkg::t_sample                  r_sample [swva_pkg::AXES];
    swva_pkg::t_sample                  n_sample [swva_pkg::AXES];
    swva_pkg::t_mean                    r_mean [swva_pkg::AXES];
    swva_pkg::t_mean                    n_mean [swva_pkg::AXES];
    logic                               r_m_valid, n_m_valid;
    logic [swva_pkg::OUT_TDATA_W-1:0]   r_m_data, n_m_data;

    logic                               in_accept;
    logic                               cfg_write;
    logic                               window_full;
    logic [swva_pkg::CNT_W-1:0]         eff_len;
    logic [swva_pkg::POS_W-1:0]         pos_sum;
    logic [swva_pkg::POS_W-1:0]         pos_wrapped;
    logic                               ram_we;
    logic                               ram_re;
    logic [swva_pkg::ENTRY_W-1:0]       ram_wdata;
    logic [swva_pkg::ENTRY_W-1:0]       ram_rdata;
    swva_pkg::t_div_req                 div_req;
    swva_pkg::t_div_rsp                 div_rsp;

    assign o_s_tready = (r_state == swva_pkg::ST_IDLE);
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign cfg_write  = psel && penable && pwrite && pready;

    always_comb begin
        if (r_len == '0) begin
            eff_len = swva_pkg::CNT_W'(1);
        end else if ((swva_pkg::CNT_W + swva_pkg::LEN_W)'(r_len)
                     > (swva_pkg::CNT_W + swva_pkg::LEN_W)'(swva_pkg::WINDOW_MAX)) begin
            eff_len = swva_pkg::CNT_W'(swva_pkg::WINDOW_MAX);
        end else begin
            eff_len = swva_pkg::CNT_W'(r_len);
        end
        window_full = (r_count >= eff_len);

        pos_sum = swva_pkg::POS_W'(r_ptr) + swva_pkg::POS_W'(r_count);
        if (pos_sum >= swva_pkg::POS_W'(swva_pkg::WINDOW_MAX)) begin
            pos_wrapped = pos_sum - swva_pkg::POS_W'(swva_pkg::WINDOW_MAX);
        end else begin
            pos_wrapped = pos_sum;
        end
    end

    assign ram_we    = (r_state == swva_pkg::ST_PUSH);
    assign ram_re    = in_accept && (swva_pkg::t_opcode'(i_s_tuser) == swva_pkg::OP_APPEND);
    assign ram_wdata = {r_sample[2], r_sample[1], r_sample[0]};

    swva_ram #(
        .WIDTH (swva_pkg::ENTRY_W),
        .DEPTH (swva_pkg::WINDOW_MAX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (pos_wrapped[swva_pkg::PTR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    assign div_req.start    = (r_state == swva_pkg::ST_DIV_START);
    assign div_req.dividend = r_sum[r_axis];
    assign div_req.divisor  = r_count;

    swva_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_ptr     = r_ptr;
        n_count   = r_count;
        n_axis    = r_axis;
        n_sum     = r_sum;
        n_sample  = r_sample;
        n_mean    = r_mean;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            swva_pkg::ST_IDLE: begin
                if (in_accept) begin
                    for (int a = 0; a < swva_pkg::AXES; a++) begin
                        n_sample[a] = i_s_tdata[a*swva_pkg::SAMPLE_W +: swva_pkg::SAMPLE_W];
                    end
                    if (swva_pkg::t_opcode'(i_s_tuser) == swva_pkg::OP_CLEAR) begin
                        n_ptr   = '0;
                        n_count = '0;
                        for (int a = 0; a < swva_pkg::AXES; a++) begin
                            n_sum[a]  = '0;
                            n_mean[a] = '0;
                        end
                        n_state = swva_pkg::ST_LOAD;
                    end else if (window_full) begin
                        n_state = swva_pkg::ST_DROP;
                    end else begin
                        n_state = swva_pkg::ST_PUSH;
                    end
                end
            end
            swva_pkg::ST_DROP: begin
                for (int a = 0; a < swva_pkg::AXES; a++) begin
                    n_sum[a] = r_sum[a] - swva_pkg::t_sum'(swva_pkg::t_sample'(
                        ram_rdata[a*swva_pkg::SAMPLE_W +: swva_pkg::SAMPLE_W]));
                end
                if (r_ptr == swva_pkg::PTR_W'(swva_pkg::WINDOW_MAX - 1)) begin
                    n_ptr = '0;
                end else begin
                    n_ptr = r_ptr + swva_pkg::PTR_W'(1);
                end
                n_count = r_count - swva_pkg::CNT_W'(1);
                n_state = swva_pkg::ST_PUSH;
            end
            swva_pkg::ST_PUSH: begin
                for (int a = 0; a < swva_pkg::AXES; a++) begin
                    n_sum[a] = r_sum[a] + swva_pkg::t_sum'(r_sample[a]);
                end
                n_count = r_count + swva_pkg::CNT_W'(1);
                n_axis  = '0;
                n_state = swva_pkg::ST_DIV_START;
            end
            swva_pkg::ST_DIV_START: begin
                n_state = swva_pkg::ST_DIV_WAIT;
            end
            swva_pkg::ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_mean[r_axis] = div_rsp.quotient;
                    if (r_axis == swva_pkg::AXIS_W'(swva_pkg::AXES - 1)) begin
                        n_state = swva_pkg::ST_LOAD;
                    end else begin
                        n_axis  = r_axis + swva_pkg::AXIS_W'(1);
                        n_state = swva_pkg::ST_DIV_START;
                    end
                end
            end
            swva_pkg::ST_LOAD: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {swva_pkg::OUT_PAD_W'(0),
                                 r_mean[2], r_mean[1], r_mean[0],
                                 r_sum[2], r_sum[1], r_sum[0],
                                 r_count};
                    n_state   = swva_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swva_pkg::ST_IDLE;
            end
        endcase

        if (cfg_write && (paddr[2] == swva_pkg::REG_WINDOW_LENGTH)) begin
            n_len   = pwdata[swva_pkg::LEN_W-1:0];
            n_ptr   = '0;
            n_count = '0;
            for (int a = 0; a < swva_pkg::AXES; a++) begin
                n_sum[a] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= swva_pkg::ST_IDLE;
            r_len     <= swva_pkg::LEN_RESET;
            r_ptr     <= '0;
            r_count   <= '0;
            r_axis    <= '0;
            r_m_valid <= 1'b0;
            for (int a = 0; a < swva_pkg::AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_ptr     <= n_ptr;
            r_count   <= n_count;
            r_axis    <= n_axis;
            r_m_valid <= n_m_valid;
            r_sum     <= n_sum;
        end
        r_sample <= n_sample;
        r_mean   <= n_mean;
        r_m_data <= n_m_data;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == swva_pkg::REG_WINDOW_LENGTH)
                      ? swva_pkg::APB_DATA_W'(r_len) : '0;

endmodule

// ----- sv/swva_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/swva_div.sv -----
// ----------------------------------------------------------------------------
// Sliding-window vector average divider
// Restoring divider, one quotient bit per cycle, that divides a signed sum by
// an unsigned count, rounds toward zero and saturates to the mean width.
// ----------------------------------------------------------------------------
module swva_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swva_pkg::t_div_req i_req,
    output swva_pkg::t_div_rsp o_rsp
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [swva_pkg::STEP_W-1:0]       r_step, n_step;
    logic                              r_neg, n_neg;
    logic [swva_pkg::SUM_W-1:0]        r_quo, n_quo;
    logic [swva_pkg::CNT_W-1:0]        r_rem, n_rem;
    logic [swva_pkg::CNT_W-1:0]        r_div, n_div;
    swva_pkg::t_mean                   r_result, n_result;

    logic [swva_pkg::CNT_W:0]          shifted;
    logic [swva_pkg::CNT_W:0]          diff;
    logic                              fits;
    logic [swva_pkg::SUM_W-1:0]        step_quo;
    logic [swva_pkg::SUM_W-1:0]        magnitude;
    swva_pkg::t_mean                   saturated;

    always_comb begin
        shifted   = {r_rem, r_quo[swva_pkg::SUM_W-1]};
        diff      = shifted - {1'b0, r_div};
        fits      = (shifted >= {1'b0, r_div});
        step_quo  = {r_quo[swva_pkg::SUM_W-2:0], fits};
        magnitude = i_req.dividend[swva_pkg::SUM_W-1]
                  ? swva_pkg::SUM_W'(0) - swva_pkg::SUM_W'(i_req.dividend)
                  : swva_pkg::SUM_W'(i_req.dividend);

        if (r_neg) begin
            if (step_quo > swva_pkg::SUM_W'(swva_pkg::MEAN_LIM)) begin
                saturated = swva_pkg::MEAN_MIN;
            end else begin
                saturated = swva_pkg::MEAN_W'(swva_pkg::SUM_W'(0) - step_quo);
            end
        end else begin
            if (step_quo > swva_pkg::SUM_W'(swva_pkg::MEAN_LIM - 1)) begin
                saturated = swva_pkg::MEAN_MAX;
            end else begin
                saturated = swva_pkg::MEAN_W'(step_quo);
            end
        end

        n_busy   = r_busy;
        n_done   = 1'b0;
        n_step   = r_step;
        n_neg    = r_neg;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_div    = r_div;
        n_result = r_result;

        if (r_busy) begin
            n_quo  = step_quo;
            n_rem  = fits ? diff[swva_pkg::CNT_W-1:0] : shifted[swva_pkg::CNT_W-1:0];
            n_step = r_step - swva_pkg::STEP_W'(1);
            if (r_step == '0) begin
                n_busy   = 1'b0;
                n_done   = 1'b1;
                n_result = saturated;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_step = swva_pkg::STEP_W'(swva_pkg::SUM_W - 1);
            n_neg  = i_req.dividend[swva_pkg::SUM_W-1];
            n_quo  = magnitude;
            n_rem  = '0;
            n_div  = i_req.divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step   <= n_step;
        r_neg    <= n_neg;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_result <= n_result;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_result;

endmodule

// ----- sv/swva_checker.sv -----
// ----------------------------------------------------------------------------
// Sliding-window vector average checker
// Port-level properties of the averager, attached to the top level by bind.
// ----------------------------------------------------------------------------
module swva_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [swva_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int CNT_W = swva_pkg::CNT_W;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Result word valid right after reset.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("Input taken again while a word is in work.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[CNT_W-1:0] <= CNT_W'(swva_pkg::WINDOW_MAX)))
        else $error("Entry count beyond the window size.");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[CNT_W-1:0] == '0))
        |-> (o_m_tdata[swva_pkg::OUT_FIELDS_W-1:CNT_W] == '0))
        else $error("Empty window reports a nonzero sum or mean.");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("Stalled result word changed.");

endmodule

bind sliding_window_vector_average swva_checker u_swva_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- sim/sliding_window_vector_average_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window vector average testbench
// Streams append and clear words into the averager, predicts count, sums and
// means of every word with an in-bench window model, and compares each output
// word in order. The window length register is rewritten over APB between
// phases, read back, and swept over zero, one, small, full and oversize
// lengths while both stream sides idle and stall in several patterns.
// ----------------------------------------------------------------------------
module sliding_window_vector_average_tb;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 100;
    localparam int RAND_LEN     = -1;
    localparam int CNT_W        = swva_pkg::CNT_W;
    localparam int AXES         = swva_pkg::AXES;
    localparam int SUM_W        = swva_pkg::SUM_W;
    localparam int MEAN_W       = swva_pkg::MEAN_W;
    localparam int WINDOW_MAX   = swva_pkg::WINDOW_MAX;
    localparam logic [swva_pkg::APB_ADDR_W-1:0] LEN_ADDR =
        swva_pkg::APB_ADDR_W'(4 * swva_pkg::REG_WINDOW_LENGTH);

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;
    typedef enum {ROW_LENGTH, ROW_WORD, ROW_TYPED} t_row_kind;

    typedef struct {
        logic [CNT_W-1:0] count;
        swva_pkg::t_sum   sum  [AXES];
        swva_pkg::t_mean  mean [AXES];
    } t_report;

    typedef struct {
        t_row_kind         kind;
        int                len;
        swva_pkg::t_opcode op;
        int                smp [AXES];
        int                res [7];
    } t_dir_row;

    typedef struct {
        int    len;
        int    items;
        t_idle mode;
        bit    extreme;
    } t_phase;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_s_tvalid = 1'b0;
    logic                               o_s_tready;
    logic [swva_pkg::IN_TDATA_W-1:0]    i_s_tdata = '0;
    logic                               i_s_tuser = 1'b0;
    logic                               o_m_tvalid;
    logic                               i_m_tready = 1'b0;
    logic [swva_pkg::OUT_TDATA_W-1:0]   o_m_tdata;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [swva_pkg::APB_ADDR_W-1:0]    paddr = '0;
    logic [swva_pkg::APB_DATA_W-1:0]    pwdata = '0;
    logic [swva_pkg::APB_DATA_W-1:0]    prdata;
    logic                               pready;

    sliding_window_vector_average dut (.*);

    always #2 i_clk = ~i_clk;

    swva_pkg::t_sample          ring [WINDOW_MAX][AXES];
    swva_pkg::t_sum             run_sum [AXES];
    int                         held_count;
    int                         oldest;
    logic [swva_pkg::LEN_W-1:0] win_len = swva_pkg::LEN_RESET;

    t_report pending_reports [$];
    t_report no_report;
    t_idle   idle_mode = IDLE_NONE;
    int      hold_requests = 0;
    int      hold_served = 0;
    int      hold_left = 0;
    int      mismatches = 0;
    int      words_sent = 0;
    int      clears_sent = 0;
    int      reports_checked = 0;
    int      length_writes = 0;
    int      cycle_count = 0;
    string   axis_name [AXES] = '{"x", "y", "z"};

    t_dir_row dir_table [28] = '{
        '{ROW_TYPED,  0, swva_pkg::OP_APPEND, '{1, -2, 3},
          '{1, 1, -2, 3, 1, -2, 3}},
        '{ROW_WORD,   0, swva_pkg::OP_APPEND, '{32767, -32768, 0},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_TYPED,  0, swva_pkg::OP_CLEAR,  '{-1, -1, -1},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_TYPED,  0, swva_pkg::OP_CLEAR,  '{0, 0, 0},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_TYPED,  0, swva_pkg::OP_APPEND, '{32767, -32768, -1},
          '{1, 32767, -32768, -1, 32767, -32768, -1}},
        '{ROW_TYPED,  0, swva_pkg::OP_APPEND, '{-32768, 32767, 0},
          '{2, -1, -1, -1, 0, 0, 0}},
        '{ROW_LENGTH, 0, swva_pkg::OP_APPEND, '{0, 0, 0},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_TYPED,  0, swva_pkg::OP_APPEND, '{100, -100, 7},
          '{1, 100, -100, 7, 100, -100, 7}},
        '{ROW_TYPED,  0, swva_pkg::OP_APPEND, '{-5, 6, 32767},
          '{1, -5, 6, 32767, -5, 6, 32767}},
        '{ROW_LENGTH, 1, swva_pkg::OP_APPEND, '{0, 0, 0},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_TYPED,  0, swva_pkg::OP_APPEND, '{32767, 32767, 32767},
          '{1, 32767, 32767, 32767, 32767, 32767, 32767}},
        '{ROW_TYPED,  0, swva_pkg::OP_APPEND, '{-32768, -32768, -32768},
          '{1, -32768, -32768, -32768, -32768, -32768, -32768}},
        '{ROW_LENGTH, 2, swva_pkg::OP_APPEND, '{0, 0, 0},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_TYPED,  0, swva_pkg::OP_APPEND, '{7, -7, 1},
          '{1, 7, -7, 1, 7, -7, 1}},
        '{ROW_WORD,   0, swva_pkg::OP_APPEND, '{2, -2, 0},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_WORD,   0, swva_pkg::OP_APPEND, '{-9, 9, 5},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_TYPED,  0, swva_pkg::OP_CLEAR,  '{21845, -21846, 1},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_LENGTH, 257, swva_pkg::OP_APPEND, '{0, 0, 0},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_WORD,   0, swva_pkg::OP_APPEND, '{21845, -21846, 0},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_WORD,   0, swva_pkg::OP_APPEND, '{-21846, 21845, -1},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_LENGTH, 256, swva_pkg::OP_APPEND, '{0, 0, 0},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_TYPED,  0, swva_pkg::OP_APPEND, '{12345, -12345, 1},
          '{1, 12345, -12345, 1, 12345, -12345, 1}},
        '{ROW_WORD,   0, swva_pkg::OP_APPEND, '{3, 3, 3},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_LENGTH, 3, swva_pkg::OP_APPEND, '{0, 0, 0},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_TYPED,  0, swva_pkg::OP_APPEND, '{-1, -1, -1},
          '{1, -1, -1, -1, -1, -1, -1}},
        '{ROW_WORD,   0, swva_pkg::OP_APPEND, '{1, 1, 1},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_WORD,   0, swva_pkg::OP_APPEND, '{1, 1, 1},
          '{0, 0, 0, 0, 0, 0, 0}},
        '{ROW_WORD,   0, swva_pkg::OP_APPEND, '{-32768, 32767, 5},
          '{0, 0, 0, 0, 0, 0, 0}}
    };

    t_phase phases [11] = '{
        '{64,       140, IDLE_NONE, 1'b0},
        '{256,      270, IDLE_RECV, 1'b1},
        '{3,        120, IDLE_SEND, 1'b0},
        '{511,      150, IDLE_BOTH, 1'b0},
        '{0,        60,  IDLE_NONE, 1'b0},
        '{1,        60,  IDLE_RECV, 1'b0},
        '{RAND_LEN, 80,  IDLE_SEND, 1'b0},
        '{RAND_LEN, 80,  IDLE_BOTH, 1'b0},
        '{RAND_LEN, 80,  IDLE_NONE, 1'b0},
        '{RAND_LEN, 80,  IDLE_RECV, 1'b0},
        '{RAND_LEN, 80,  IDLE_BOTH, 1'b0}
    };

    function automatic int send_idle_pct(t_idle mode);
        return (mode == IDLE_SEND) ? 59 : (mode == IDLE_BOTH) ? 16 : 0;
    endfunction

    function automatic int recv_idle_pct(t_idle mode);
        return (mode == IDLE_RECV) ? 59 : (mode == IDLE_BOTH) ? 16 : 0;
    endfunction

    function automatic void empty_window();
        held_count = 0;
        oldest     = 0;
        for (int a = 0; a < AXES; a++) run_sum[a] = '0;
    endfunction

    function automatic t_report advance_window(swva_pkg::t_opcode op, swva_pkg::t_sample sx,
                                               swva_pkg::t_sample sy, swva_pkg::t_sample sz);
        t_report           rep;
        swva_pkg::t_sample smp [AXES];
        int                span;
        int                pos;
        longint            quo;
        smp[0] = sx;
        smp[1] = sy;
        smp[2] = sz;
        if (op == swva_pkg::OP_CLEAR) begin
            empty_window();
        end else begin
            span = (win_len == 0) ? 1 : (int'(win_len) > WINDOW_MAX) ? WINDOW_MAX : int'(win_len);
            if (held_count >= span) begin
                for (int a = 0; a < AXES; a++) run_sum[a] = run_sum[a] - ring[oldest][a];
                oldest     = (oldest + 1) % WINDOW_MAX;
                held_count = held_count - 1;
            end
            pos = (oldest + held_count) % WINDOW_MAX;
            for (int a = 0; a < AXES; a++) begin
                ring[pos][a] = smp[a];
                run_sum[a]   = run_sum[a] + smp[a];
            end
            held_count = held_count + 1;
        end
        rep.count = CNT_W'(held_count);
        for (int a = 0; a < AXES; a++) begin
            rep.sum[a] = run_sum[a];
            quo = (held_count == 0) ? 0 : longint'(run_sum[a]) / longint'(held_count);
            if (quo > swva_pkg::MEAN_LIM - 1) rep.mean[a] = swva_pkg::MEAN_MAX;
            else if (quo < -swva_pkg::MEAN_LIM) rep.mean[a] = swva_pkg::MEAN_MIN;
            else rep.mean[a] = swva_pkg::t_mean'(quo);
        end
        return rep;
    endfunction

    function automatic swva_pkg::t_sample rand_sample();
        unique case ($urandom_range(0, 7))
            0: begin
                return swva_pkg::t_sample'(swva_pkg::MEAN_MAX);
            end
            1: begin
                return swva_pkg::t_sample'(swva_pkg::MEAN_MIN);
            end
            default: begin
                return swva_pkg::t_sample'($urandom);
            end
        endcase
    endfunction

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic wait_for_reports();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic read_window_length(input int unsigned want);
        logic [swva_pkg::APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= LEN_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("window_length readback", longint'(want), longint'(readback));
    endtask

    task automatic write_window_length(input int unsigned len);
        wait_for_reports();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LEN_ADDR;
        pwdata  <= swva_pkg::APB_DATA_W'(len);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        win_len = swva_pkg::LEN_W'(len);
        empty_window();
        length_writes++;
        read_window_length(len);
    endtask

    task automatic send_word(input swva_pkg::t_opcode op, input swva_pkg::t_sample sx,
                             input swva_pkg::t_sample sy, input swva_pkg::t_sample sz,
                             input bit use_typed, input t_report typed_rep);
        t_report rep;
        while ($urandom_range(0, 99) < send_idle_pct(idle_mode)) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {sz, sy, sx};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        rep = advance_window(op, sx, sy, sz);
        pending_reports.push_back(use_typed ? typed_rep : rep);
        words_sent++;
        if (op == swva_pkg::OP_CLEAR) clears_sent++;
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct(idle_mode));
        end
    end

    always @(posedge i_clk) begin
        t_report want;
        t_report got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.count = o_m_tdata[CNT_W-1:0];
            for (int a = 0; a < AXES; a++) begin
                got.sum[a]  = o_m_tdata[CNT_W + a * SUM_W +: SUM_W];
                got.mean[a] = o_m_tdata[CNT_W + AXES * SUM_W + a * MEAN_W +: MEAN_W];
            end
            if (pending_reports.size() == 0) begin
                $display("%0t ns: output word with no expectation, %s %0d",
                         $time, "expected none, actual count", got.count);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("entry_count", longint'(want.count), longint'(got.count));
                for (int a = 0; a < AXES; a++) begin
                    check_field({"sum_", axis_name[a]}, longint'(want.sum[a]),
                                longint'(got.sum[a]));
                    check_field({"mean_", axis_name[a]}, longint'(want.mean[a]),
                                longint'(got.mean[a]));
                end
                reports_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL sliding_window_vector_average");
            $finish;
        end
    end

    initial begin
        t_report           typed_rep;
        swva_pkg::t_opcode op;
        swva_pkg::t_sample sx;
        swva_pkg::t_sample sy;
        swva_pkg::t_sample sz;
        int                len;
        empty_window();
        no_report = advance_window(swva_pkg::OP_CLEAR, '0, '0, '0);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_window_length(swva_pkg::LEN_RESET);

        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_LENGTH) begin
                write_window_length(dir_table[i].len);
            end else begin
                typed_rep.count = CNT_W'(dir_table[i].res[0]);
                for (int a = 0; a < AXES; a++) begin
                    typed_rep.sum[a]  = swva_pkg::t_sum'(dir_table[i].res[1 + a]);
                    typed_rep.mean[a] = swva_pkg::t_mean'(dir_table[i].res[4 + a]);
                end
                send_word(dir_table[i].op, swva_pkg::t_sample'(dir_table[i].smp[0]),
                          swva_pkg::t_sample'(dir_table[i].smp[1]),
                          swva_pkg::t_sample'(dir_table[i].smp[2]),
                          dir_table[i].kind == ROW_TYPED, typed_rep);
            end
        end

        foreach (phases[p]) begin
            len = (phases[p].len == RAND_LEN) ? $urandom_range(2, 255) : phases[p].len;
            write_window_length(len);
            idle_mode = phases[p].mode;
            for (int n = 0; n < phases[p].items; n++) begin
                if (p == 0 && n == 40) hold_requests++;
                if (p == 2 && n == 60) wait_for_reports();
                if (phases[p].extreme) begin
                    op = swva_pkg::OP_APPEND;
                    sx = swva_pkg::t_sample'(swva_pkg::MEAN_MAX);
                    sy = swva_pkg::t_sample'(swva_pkg::MEAN_MIN);
                end else begin
                    op = ($urandom_range(0, 39) == 0) ? swva_pkg::OP_CLEAR : swva_pkg::OP_APPEND;
                    sx = rand_sample();
                    sy = rand_sample();
                end
                sz = rand_sample();
                send_word(op, sx, sy, sz, 1'b0, no_report);
            end
        end

        idle_mode = IDLE_NONE;
        wait_for_reports();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_reports.size() != 0) begin
            $display("%0t ns: missing output words, expected 0 pending, actual %0d",
                     $time, pending_reports.size());
            mismatches++;
        end
        $display("Run covered %0d words (%0d clears) and %0d checked output words,",
                 words_sent, clears_sent, reports_checked);
        $display("with %0d window length writes from 0 to 511 under four idle patterns.",
                 length_writes);
        if (mismatches == 0) begin
            $display("PASS sliding_window_vector_average");
        end else begin
            $display("FAIL sliding_window_vector_average");
        end
        $finish;
    end

endmodule

// ----- sliding_window_vector_average.f -----
sv/swva_pkg.sv
sv/swva_ram.sv
sv/swva_div.sv
sv/sliding_window_vector_average.sv
sv/swva_checker.sv
sim/sliding_window_vector_average_tb.sv
